### rtl/bcps_pkg.sv
// ----------------------------------------------------------------------------
// bcps_pkg
// widths, constants and shared types of the bezier control point smoother
// ----------------------------------------------------------------------------
package bcps_pkg;

  localparam int CW   = 24;           // coordinate width
  localparam int SW   = 17;           // smoothing factor width, q1.16
  localparam int DW   = CW + 1;       // coordinate difference width
  localparam int SQW  = 2 * DW;       // sum of two squares
  localparam int LW   = DW;           // segment length width
  localparam int RW   = LW + 2;       // square root remainder width
  localparam int SUMW = LW + 1;       // length sum width
  localparam int QW   = 17;           // ratio / weight width, q1.16
  localparam int NW   = LW + QW;      // ratio numerator width
  localparam int PW   = DW + QW + 1;  // offset product width
  localparam int OW   = DW + 1;       // rounded offset width

  localparam logic [QW-1:0] ONE_Q16  = QW'(65536);
  localparam logic [QW-1:0] HALF_Q16 = QW'(32768);
  localparam logic [SW-1:0] SMOOTH_RESET = SW'(32768);

  // words carried alongside the length and ratio pipes
  typedef struct packed {
    logic signed [DW-1:0] d1x;  // end - prev
    logic signed [DW-1:0] d1y;
    logic signed [DW-1:0] d2x;  // start - next
    logic signed [DW-1:0] d2y;
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] ex;
    logic signed [CW-1:0] ey;
  } side_t;

endpackage

### rtl/bcps_ifs.sv
// ----------------------------------------------------------------------------
// bcps channel interfaces
// point word, control point word and smoothing register write channel
// ----------------------------------------------------------------------------
interface bcps_pts_if;
  logic valid;
  logic ready;
  logic signed [23:0] prev_x;
  logic signed [23:0] prev_y;
  logic signed [23:0] start_x;
  logic signed [23:0] start_y;
  logic signed [23:0] end_x;
  logic signed [23:0] end_y;
  logic signed [23:0] next_x;
  logic signed [23:0] next_y;
  modport source (output valid, prev_x, prev_y, start_x, start_y, end_x, end_y,
                  next_x, next_y, input ready);
  modport sink (input valid, prev_x, prev_y, start_x, start_y, end_x, end_y,
                next_x, next_y, output ready);
endinterface

interface bcps_ctl_if;
  logic valid;
  logic ready;
  logic signed [23:0] ctrl1_x;
  logic signed [23:0] ctrl1_y;
  logic signed [23:0] ctrl2_x;
  logic signed [23:0] ctrl2_y;
  logic degenerate;
  logic clipped;
  modport source (output valid, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, degenerate,
                  clipped, input ready);
  modport sink (input valid, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, degenerate,
                clipped, output ready);
endinterface

interface bcps_cfg_if;
  logic valid;
  logic ready;
  logic [16:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### rtl/bcps_len.sv
// ----------------------------------------------------------------------------
// bcps_len
// three-lane pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module bcps_len (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_vld,
  input  logic [bcps_pkg::SQW-1:0] sq1,
  input  logic [bcps_pkg::SQW-1:0] sq2,
  input  logic [bcps_pkg::SQW-1:0] sq3,
  input  bcps_pkg::side_t        in_side,
  output logic                   out_vld,
  output logic [bcps_pkg::LW-1:0] len1,
  output logic [bcps_pkg::LW-1:0] len2,
  output logic [bcps_pkg::LW-1:0] len3,
  output bcps_pkg::side_t        out_side
);
  import bcps_pkg::*;

  logic [SQW-1:0] sq_in [3];
  logic [SQW-1:0] val_q  [LW][3];
  logic [RW-1:0]  rem_q  [LW][3];
  logic [LW-1:0]  root_q [LW][3];
  logic [RW-1:0]  rem_d  [LW][3];
  logic [LW-1:0]  root_d [LW][3];
  logic [SQW-1:0] val_d  [LW][3];
  logic           vld_q  [LW];
  side_t          side_q [LW];

  assign sq_in[0] = sq1;
  assign sq_in[1] = sq2;
  assign sq_in[2] = sq3;

  always_comb begin
    logic [SQW-1:0] v;
    logic [RW-1:0]  r;
    logic [LW-1:0]  rt;
    logic [RW+1:0]  rn;
    logic [RW+1:0]  tr;
    for (int k = 0; k < LW; k++) begin
      for (int l = 0; l < 3; l++) begin
        v  = (k == 0) ? sq_in[l] : val_q[k-1][l];
        r  = (k == 0) ? '0 : rem_q[k-1][l];
        rt = (k == 0) ? '0 : root_q[k-1][l];
        rn = {r, v[2*(LW-1-k) +: 2]};
        tr = (RW+2)'({rt, 2'b01});
        val_d[k][l] = v;
        if (rn >= tr) begin
          rem_d[k][l]  = RW'(rn - tr);
          root_d[k][l] = {rt[LW-2:0], 1'b1};
        end else begin
          rem_d[k][l]  = RW'(rn);
          root_d[k][l] = {rt[LW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < LW; k++) begin
        for (int l = 0; l < 3; l++) begin
          val_q[k][l]  <= val_d[k][l];
          rem_q[k][l]  <= rem_d[k][l];
          root_q[k][l] <= root_d[k][l];
        end
        side_q[k] <= (k == 0) ? in_side : side_q[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LW; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < LW; k++) vld_q[k] <= (k == 0) ? in_vld : vld_q[k-1];
    end
  end

  assign out_vld  = vld_q[LW-1];
  assign len1     = root_q[LW-1][0];
  assign len2     = root_q[LW-1][1];
  assign len3     = root_q[LW-1][2];
  assign out_side = side_q[LW-1];

endmodule

### rtl/bcps_ratio.sv
// ----------------------------------------------------------------------------
// bcps_ratio
// two-lane pipelined restoring divider for the length split ratios
// ----------------------------------------------------------------------------
module bcps_ratio (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_vld,
  input  logic [bcps_pkg::LW-1:0] len1,
  input  logic [bcps_pkg::LW-1:0] len2,
  input  logic [bcps_pkg::LW-1:0] len3,
  input  bcps_pkg::side_t         in_side,
  output logic                    out_vld,
  output logic [bcps_pkg::QW-1:0] k1,
  output logic [bcps_pkg::QW-1:0] k2,
  output logic                    degenerate,
  output bcps_pkg::side_t         out_side
);
  import bcps_pkg::*;

  localparam int NS = QW + 1;  // prep stage plus one stage per quotient bit

  logic [SUMW-1:0] sum_q [NS][2];
  logic [NW-1:0]   num_q [NS][2];
  logic [QW-1:0]   quo_q [NS][2];
  logic            zero_q [NS][2];
  logic            vld_q  [NS];
  side_t           side_q [NS];
  logic [NW-1:0]   num_d [NS][2];
  logic [QW-1:0]   quo_d [NS][2];
  logic [LW-1:0]   la [2];
  logic [LW-1:0]   lb [2];
  logic [SUMW-1:0] sum_in [2];

  assign la[0] = len1;
  assign lb[0] = len2;
  assign la[1] = len2;
  assign lb[1] = len3;

  always_comb begin
    logic [NW:0] dv;
    logic [NW:0] nx;
    for (int l = 0; l < 2; l++) begin
      sum_in[l]   = SUMW'(la[l]) + SUMW'(lb[l]);
      num_d[0][l] = NW'({la[l], 16'h0000}) + NW'(sum_in[l] >> 1);
      quo_d[0][l] = '0;
      for (int k = 1; k < NS; k++) begin
        dv = (NW+1)'(sum_q[k-1][l]) << (QW - k);
        nx = (NW+1)'(num_q[k-1][l]);
        if (nx >= dv) begin
          num_d[k][l] = NW'(nx - dv);
          quo_d[k][l] = {quo_q[k-1][l][QW-2:0], 1'b1};
        end else begin
          num_d[k][l] = num_q[k-1][l];
          quo_d[k][l] = {quo_q[k-1][l][QW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NS; k++) begin
        for (int l = 0; l < 2; l++) begin
          sum_q[k][l]  <= (k == 0) ? sum_in[l] : sum_q[k-1][l];
          zero_q[k][l] <= (k == 0) ? (sum_in[l] == '0) : zero_q[k-1][l];
          num_q[k][l]  <= num_d[k][l];
          quo_q[k][l]  <= quo_d[k][l];
        end
        side_q[k] <= (k == 0) ? in_side : side_q[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NS; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < NS; k++) vld_q[k] <= (k == 0) ? in_vld : vld_q[k-1];
    end
  end

  // a zero length sum forces the ratio to zero
  assign k1         = zero_q[NS-1][0] ? '0 : quo_q[NS-1][0];
  assign k2         = zero_q[NS-1][1] ? '0 : quo_q[NS-1][1];
  assign degenerate = zero_q[NS-1][0] | zero_q[NS-1][1];
  assign out_vld    = vld_q[NS-1];
  assign out_side   = side_q[NS-1];

endmodule

### rtl/bezier_control_point_smoother_top.sv
// ----------------------------------------------------------------------------
// bezier_control_point_smoother_top
// inner cubic bezier control points of a polyline segment, fully pipelined
// ----------------------------------------------------------------------------
// usage
//   pts carries one word per segment: prev, start, end and next points in
//   signed q16.8. ctl returns one word per segment: the two inner control
//   points, a degenerate flag (a length sum was zero) and a clipped flag
//   (a control coordinate saturated).
//   cfg writes the 17-bit smoothing factor (q1.16, values above 1.0 act as
//   1.0); it is always ready and should be written only while idle.
// pipeline and throughput
//   stages in order: differences and squares, square root (one root bit
//   per stage), ratio divide (prep plus one quotient bit per stage), then
//   weight, product and output. one word per cycle is accepted in steady
//   state while ctl does not stall.
// reset
//   rst clears every stage valid bit and sets the smoothing factor to 0.5.
// stall
//   while a result waits on ctl and ready is low the whole pipe holds;
//   pts.ready falls with it and nothing is lost or repeated.
// ----------------------------------------------------------------------------
module bezier_control_point_smoother_top (
  input logic clk,
  input logic rst,
  bcps_pts_if.sink   pts,
  bcps_ctl_if.source ctl,
  bcps_cfg_if.sink   cfg
);
  import bcps_pkg::*;

  // global advance: pipe moves unless a result sits unread
  logic en;
  logic out_vld;
  assign en        = !out_vld || ctl.ready;
  assign pts.ready = en;

  // smoothing register
  logic [SW-1:0] smooth;
  logic [QW-1:0] s_eff;
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      smooth <= SMOOTH_RESET;
    end else if (cfg.valid) begin
      smooth <= cfg.data;
    end
  end
  assign s_eff = (smooth > SW'(ONE_Q16)) ? ONE_Q16 : QW'(smooth);

  // stage 1: differences and magnitudes
  logic          s1_vld;
  logic [DW-1:0] m_q [6];
  side_t         s1_side;
  logic signed [DW-1:0] dd [6];

  always_comb begin
    dd[0] = DW'(pts.start_x) - DW'(pts.prev_x);
    dd[1] = DW'(pts.start_y) - DW'(pts.prev_y);
    dd[2] = DW'(pts.end_x) - DW'(pts.start_x);
    dd[3] = DW'(pts.end_y) - DW'(pts.start_y);
    dd[4] = DW'(pts.next_x) - DW'(pts.end_x);
    dd[5] = DW'(pts.next_y) - DW'(pts.end_y);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 6; i++) m_q[i] <= dd[i][DW-1] ? DW'(-dd[i]) : DW'(dd[i]);
      s1_side.d1x <= DW'(pts.end_x) - DW'(pts.prev_x);
      s1_side.d1y <= DW'(pts.end_y) - DW'(pts.prev_y);
      s1_side.d2x <= DW'(pts.start_x) - DW'(pts.next_x);
      s1_side.d2y <= DW'(pts.start_y) - DW'(pts.next_y);
      s1_side.sx  <= pts.start_x;
      s1_side.sy  <= pts.start_y;
      s1_side.ex  <= pts.end_x;
      s1_side.ey  <= pts.end_y;
    end
  end

  // stage 2: sums of squares
  logic           s2_vld;
  logic [SQW-1:0] sq_q [3];
  side_t          s2_side;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= SQW'(m_q[2*i]) * SQW'(m_q[2*i]) + SQW'(m_q[2*i+1]) * SQW'(m_q[2*i+1]);
      end
      s2_side <= s1_side;
    end
  end

  // segment lengths
  logic          ln_vld;
  logic [LW-1:0] len1, len2, len3;
  side_t         ln_side;
  bcps_len u_len (
    .clk(clk), .rst(rst), .en(en), .in_vld(s2_vld),
    .sq1(sq_q[0]), .sq2(sq_q[1]), .sq3(sq_q[2]), .in_side(s2_side),
    .out_vld(ln_vld), .len1(len1), .len2(len2), .len3(len3), .out_side(ln_side)
  );

  // split ratios
  logic          rt_vld;
  logic [QW-1:0] k1, k2;
  logic          rt_degen;
  side_t         rt_side;
  bcps_ratio u_ratio (
    .clk(clk), .rst(rst), .en(en), .in_vld(ln_vld),
    .len1(len1), .len2(len2), .len3(len3), .in_side(ln_side),
    .out_vld(rt_vld), .k1(k1), .k2(k2), .degenerate(rt_degen), .out_side(rt_side)
  );

  // weight stage: w1 = (1-k1)*s, w2 = k2*s, rounded
  logic          w_vld;
  logic [QW-1:0] w1, w2;
  logic          w_degen;
  side_t         w_side;
  logic [2*QW:0] wp1, wp2;
  always_comb begin
    wp1 = (2*QW+1)'(ONE_Q16 - k1) * (2*QW+1)'(s_eff) + (2*QW+1)'(HALF_Q16);
    wp2 = (2*QW+1)'(k2) * (2*QW+1)'(s_eff) + (2*QW+1)'(HALF_Q16);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      w1      <= wp1[16 +: QW];
      w2      <= wp2[16 +: QW];
      w_degen <= rt_degen;
      w_side  <= rt_side;
    end
  end

  // product stage: offsets = floor((d*w + 2^16) / 2^17)
  localparam logic signed [PW-1:0] RND = PW'(65536);
  logic                 p_vld;
  logic signed [OW-1:0] off_q [4];
  logic                 p_degen;
  side_t                p_side;
  logic signed [PW-1:0] pr [4];
  always_comb begin
    pr[0] = PW'(w_side.d1x) * PW'(signed'({1'b0, w1})) + RND;
    pr[1] = PW'(w_side.d1y) * PW'(signed'({1'b0, w1})) + RND;
    pr[2] = PW'(w_side.d2x) * PW'(signed'({1'b0, w2})) + RND;
    pr[3] = PW'(w_side.d2y) * PW'(signed'({1'b0, w2})) + RND;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) off_q[i] <= OW'(pr[i] >>> QW);
      p_degen <= w_degen;
      p_side  <= w_side;
    end
  end

  // output stage: add base point and saturate
  localparam logic signed [OW:0] CMAX = (OW+1)'((64'sd1 <<< (CW-1)) - 64'sd1);
  localparam logic signed [OW:0] CMIN = (OW+1)'(-(64'sd1 <<< (CW-1)));
  logic signed [OW:0] cs [4];
  logic signed [CW-1:0] cq [4];
  logic [3:0] cl;
  always_comb begin
    cs[0] = (OW+1)'(p_side.sx) + (OW+1)'(off_q[0]);
    cs[1] = (OW+1)'(p_side.sy) + (OW+1)'(off_q[1]);
    cs[2] = (OW+1)'(p_side.ex) + (OW+1)'(off_q[2]);
    cs[3] = (OW+1)'(p_side.ey) + (OW+1)'(off_q[3]);
    for (int i = 0; i < 4; i++) begin
      if (cs[i] > CMAX) begin
        cq[i] = CW'(CMAX);
        cl[i] = 1'b1;
      end else if (cs[i] < CMIN) begin
        cq[i] = CW'(CMIN);
        cl[i] = 1'b1;
      end else begin
        cq[i] = CW'(cs[i]);
        cl[i] = 1'b0;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ctl.ctrl1_x    <= cq[0];
      ctl.ctrl1_y    <= cq[1];
      ctl.ctrl2_x    <= cq[2];
      ctl.ctrl2_y    <= cq[3];
      ctl.degenerate <= p_degen;
      ctl.clipped    <= |cl;
    end
  end

  // valid bits of the stages held in this module
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld  <= 1'b0;
      s2_vld  <= 1'b0;
      w_vld   <= 1'b0;
      p_vld   <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      s1_vld  <= pts.valid;
      s2_vld  <= s1_vld;
      w_vld   <= rt_vld;
      p_vld   <= w_vld;
      out_vld <= p_vld;
    end
  end
  assign ctl.valid = out_vld;

  // stalled pipe keeps its inner valid bits
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(w_vld) && $stable(p_vld) && $stable(rt_vld))
    else $error("pipe moved while stalled");

  // weights never exceed one
  a_weight_bound: assert property (@(posedge clk) disable iff (rst)
    w_vld |-> (w1 <= ONE_Q16) && (w2 <= ONE_Q16))
    else $error("weight above one");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_vld && !w_vld)
    else $error("valid after reset");

endmodule

### bench/bcps_tb_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcps testbench package
// note: the channel interfaces come with the rtl; this file adds only the bench data types, nothing more
// ----------------------------------------------------------------------------
package bcps_tb_pkg;
  import bcps_pkg::*;

  typedef struct {
    logic signed [23:0] px, py, sx, sy, ex, ey, nx, ny;
  } quad_t;

  typedef struct {
    logic signed [23:0] c1x, c1y, c2x, c2y;
    logic degen, clip;
  } ctl_word_t;
endpackage

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives point quadruples into the bezier control point smoother with bursty
// traffic and output stalls, predicts each control point word in integer
// arithmetic and compares every field in order
// ----------------------------------------------------------------------------
module testbench;
  import bcps_pkg::*;
  import bcps_tb_pkg::*;

  localparam int LATENCY = 48;

  logic clk = 0;
  logic rst = 1;

  bcps_pts_if pts ();
  bcps_ctl_if ctl ();
  bcps_cfg_if cfg ();

  bezier_control_point_smoother_top u_dut (
    .clk(clk), .rst(rst), .pts(pts), .ctl(ctl), .cfg(cfg)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // predictor copy of the smoothing register
  logic [16:0] smooth_q16;

  quad_t     pending_quads[$];
  ctl_word_t expected_ctl[$];
  int        mismatch_count = 0;

  // floor square root of a sum of squares (fits 50 bits, use 64)
  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned root, rem, trial;
    root = 0;
    rem = 0;
    for (int i = 31; i >= 0; i--) begin
      rem = (rem << 2) | ((v >> (2 * i)) & 3);
      trial = (root << 2) | 1;
      if (rem >= trial) begin
        rem -= trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic longint unsigned seg_length(longint dx, longint dy);
    return isqrt(longint'(dx * dx + dy * dy));
  endfunction

  function automatic longint unsigned split_ratio(longint unsigned a,
      longint unsigned b, ref bit degen);
    longint unsigned sum;
    sum = a + b;
    if (sum == 0) begin
      degen = 1;
      return 0;
    end
    return ((a << 16) + (sum >> 1)) / sum;
  endfunction

  function automatic logic signed [23:0] clamp24(longint v, ref bit clip);
    if (v > 8388607) begin
      clip = 1;
      return 24'sh7fffff;
    end
    if (v < -8388608) begin
      clip = 1;
      return 24'sh800000;
    end
    return v[23:0];
  endfunction

  function automatic ctl_word_t predict_ctl(quad_t q);
    ctl_word_t r;
    longint px, py, sx, sy, ex, ey, nx, ny;
    longint unsigned l1, l2, l3, k1, k2, w1, w2, s;
    bit degen, clip;
    px = q.px; py = q.py; sx = q.sx; sy = q.sy;
    ex = q.ex; ey = q.ey; nx = q.nx; ny = q.ny;
    degen = 0;
    clip = 0;
    s = (smooth_q16 > 17'd65536) ? 65536 : smooth_q16;
    l1 = seg_length(sx - px, sy - py);
    l2 = seg_length(ex - sx, ey - sy);
    l3 = seg_length(nx - ex, ny - ey);
    k1 = split_ratio(l1, l2, degen);
    k2 = split_ratio(l2, l3, degen);
    w1 = ((65536 - k1) * s + 32768) >> 16;
    w2 = (k2 * s + 32768) >> 16;
    // arithmetic shift floors, giving round half up
    r.c1x = clamp24(sx + (((ex - px) * longint'(w1) + 65536) >>> 17), clip);
    r.c1y = clamp24(sy + (((ey - py) * longint'(w1) + 65536) >>> 17), clip);
    r.c2x = clamp24(ex + (((sx - nx) * longint'(w2) + 65536) >>> 17), clip);
    r.c2y = clamp24(ey + (((sy - ny) * longint'(w2) + 65536) >>> 17), clip);
    r.degen = degen;
    r.clip = clip;
    return r;
  endfunction

  function automatic logic signed [23:0] rand_coord(int mode);
    case (mode)
      0: return 24'($urandom);
      1: return 24'($urandom_range(0, 4000) - 2000);
      2: return $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
      default: return 24'($urandom_range(0, 200000) - 100000);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // driver: bursts of random length separated by random gaps
  // ---------------------------------------------------------------------------
  int  burst_left = 0;
  int  gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      pts.valid <= 0;
    end else begin
      // word taken this edge, or nothing shown yet
      if (!pts.valid || pts.ready) begin
        if (pts.valid) begin
          expected_ctl.push_back(predict_ctl(pending_quads.pop_front()));
        end
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          pts.valid <= 0;
        end else if (pending_quads.size() > 0) begin
          pts.valid   <= 1;
          pts.prev_x  <= pending_quads[0].px;
          pts.prev_y  <= pending_quads[0].py;
          pts.start_x <= pending_quads[0].sx;
          pts.start_y <= pending_quads[0].sy;
          pts.end_x   <= pending_quads[0].ex;
          pts.end_y   <= pending_quads[0].ey;
          pts.next_x  <= pending_quads[0].nx;
          pts.next_y  <= pending_quads[0].ny;
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(0, 30);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          pts.valid <= 0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: stalls ready on its own pattern and checks each word
  // ---------------------------------------------------------------------------
  int stall_phase = 0;

  always @(posedge clk) begin
    ctl_word_t want;
    if (rst) begin
      ctl.ready <= 0;
    end else begin
      if (ctl.valid && ctl.ready) begin
        if (expected_ctl.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected control word at %0t", $realtime);
        end else begin
          want = expected_ctl.pop_front();
          if (ctl.ctrl1_x !== want.c1x || ctl.ctrl1_y !== want.c1y ||
              ctl.ctrl2_x !== want.c2x || ctl.ctrl2_y !== want.c2y ||
              ctl.degenerate !== want.degen || ctl.clipped !== want.clip) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: exp %0d %0d %0d %0d d%0b c%0b got %0d %0d %0d %0d d%0b c%0b",
                       want.c1x, want.c1y, want.c2x, want.c2y, want.degen, want.clip,
                       ctl.ctrl1_x, ctl.ctrl1_y, ctl.ctrl2_x, ctl.ctrl2_y,
                       ctl.degenerate, ctl.clipped);
          end
        end
      end
      // long open windows, then a phase of random ready
      stall_phase <= (stall_phase + 1) % 97;
      if (stall_phase < 40) ctl.ready <= 1;
      else ctl.ready <= ($urandom_range(0, 2) != 0);
    end
  end

  task automatic wait_drained();
    while (pending_quads.size() > 0 || pts.valid || expected_ctl.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // smoothing register writes only while the pipe is empty
  task automatic write_smooth(logic [16:0] v);
    cfg.valid <= 1;
    cfg.data  <= v;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 0;
    smooth_q16 = v;
  endtask

  task automatic add_quad(longint px, longint py, longint sx, longint sy,
                          longint ex, longint ey, longint nx, longint ny);
    quad_t q;
    q.px = 24'(px); q.py = 24'(py); q.sx = 24'(sx); q.sy = 24'(sy);
    q.ex = 24'(ex); q.ey = 24'(ey); q.nx = 24'(nx); q.ny = 24'(ny);
    pending_quads.push_back(q);
  endtask

  task automatic add_random(int count);
    quad_t q;
    int mode;
    for (int i = 0; i < count; i++) begin
      mode = $urandom_range(0, 9);
      if (mode < 5) begin
        // polyline-like neighborhood around a random anchor
        q.sx = 24'(rand_coord(0) / 4);
        q.sy = 24'(rand_coord(0) / 4);
        q.px = q.sx + rand_coord(1 + (i & 2));
        q.py = q.sy + rand_coord(1 + (i & 2));
        q.ex = q.sx + rand_coord(1 + (i & 2));
        q.ey = q.sy + rand_coord(1 + (i & 2));
        q.nx = q.ex + rand_coord(1);
        q.ny = q.ey + rand_coord(1);
        if (mode == 4) begin
          q.px = q.sx; q.py = q.sy; q.ex = q.sx; q.ey = q.sy;
        end
      end else begin
        q.px = rand_coord(mode & 2); q.py = rand_coord(0);
        q.sx = rand_coord(mode & 2); q.sy = rand_coord(0);
        q.ex = rand_coord(0);        q.ey = rand_coord(mode & 2);
        q.nx = rand_coord(0);        q.ny = rand_coord(mode & 2);
      end
      pending_quads.push_back(q);
    end
  endtask

  initial begin
    cfg.valid = 0;
    cfg.data = 0;
    pts.valid = 0;
    pts.prev_x = 0; pts.prev_y = 0; pts.start_x = 0; pts.start_y = 0;
    pts.end_x = 0; pts.end_y = 0; pts.next_x = 0; pts.next_y = 0;
    ctl.ready = 0;
    smooth_q16 = SMOOTH_RESET;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: reset smoothing, degenerate, extremes, saturation
    add_quad(0, 0, 0, 0, 0, 0, 0, 0);                       // all lengths zero
    add_quad(0, 0, 0, 0, 256, 0, 512, 0);                   // first length zero
    add_quad(0, 0, 256, 0, 256, 0, 256, 0);                 // second sum zero
    add_quad(-256, 0, 0, 0, 256, 256, 512, 0);
    add_quad(-8388608, -8388608, 8388607, 8388607,
             -8388608, -8388608, 8388607, 8388607);         // max differences
    add_quad(8388607, 8388607, -8388608, -8388608,
             8388607, 8388607, -8388608, -8388608);
    add_quad(-8388608, 0, 8388607, 0, 8388607, 100, -8388608, 5);
    add_quad(0, -8388608, 8388000, 8388000, 8388607, 8388607, 0, 0);
    add_quad(1, -1, 0, 0, -1, 1, 3, 3);                     // rounding halves
    add_quad(-1, -1, -1, -1, -1, -1, -1, -1);
    wait_drained();

    write_smooth(17'd65536);
    add_quad(-8388608, -8388608, 8388607, 8388607,
             -8388608, -8388608, 8388607, 8388607);
    add_quad(8388607, -8388608, -8388608, 8388607, 8388607, 0, -8388608, 0);
    add_quad(100, 100, 200, 300, 400, 350, 600, 100);
    add_random(8);
    wait_drained();

    write_smooth(17'h1ffff);                                // above one
    add_random(8);
    wait_drained();

    write_smooth(17'd0);
    add_random(6);
    wait_drained();

    // random phases with varied settings; the drain doubles as the pause
    for (int ph = 0; ph < 6; ph++) begin
      write_smooth((ph == 5) ? 17'd1 : 17'($urandom_range(0, 131071)));
      add_random(100);
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### filelist.f
rtl/bcps_pkg.sv
rtl/bcps_ifs.sv
rtl/bcps_len.sv
rtl/bcps_ratio.sv
rtl/bezier_control_point_smoother_top.sv
bench/bcps_tb_ifs.sv
bench/testbench.sv
